// File: hdl/nmea_line_checksum_checker_macros.svh
// assertion macros shared by the checker rtl
`ifndef NMEA_LINE_CHECKSUM_CHECKER_MACROS_SVH
`define NMEA_LINE_CHECKSUM_CHECKER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define NLCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nlcc check failed");

// consequent must hold in the cycle after the antecedent
`define NLCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nlcc check failed");

`endif

// File: hdl/nlcc_pkg.sv
package nlcc_pkg;

	// line buffer size, one slot kept back
	localparam int LINE_CAPACITY = 96;
	localparam int CNT_W = $clog2(LINE_CAPACITY);
	localparam int LEN_W = 7;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_NUL    = 8'h00;

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_PLAIN  = 2'd1,
		PH_BODY   = 2'd2,
		PH_DIGITS = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_EMPTY = 2'd0,
		ST_PLAIN = 2'd1,
		ST_GOOD  = 2'd2,
		ST_BAD   = 2'd3
	} status_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nibble;
	} hex_t;

	typedef struct packed {
		status_t          status;
		logic [LEN_W-1:0] length;
		logic [7:0]       comp;
		logic [7:0]       recv;
	} line_result_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		r.ok = 1'b1;
		r.nibble = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.nibble = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r.nibble = c[3:0] + 4'd9;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

// File: hdl/nmea_line_checksum_checker.sv
// nmea line checksum checker
// byte channel: data_byte with byte_valid/byte_ready, one serial byte per word
//   carriage returns are skipped, a newline closes the line
// line channel: line_status, line_length, computed_checksum, received_checksum
//   with line_valid/line_ready, one word per newline and none otherwise
// status: empty line, not nmea, nmea with good checksum, nmea with bad checksum
// throughput: one byte word per cycle unless a newline waits behind an untaken
//   line word, set by the single update of the line state (xor, compare, count)
// path: a newline word accepted into the input register moves on to the
//   result register, which offers its line word; it waits in the input
//   register while an untaken line word still holds the result register
// reset: the input and result registers empty and the line state clears to an
//   empty line; no clearing pass is needed
// stall: the result register holds a finished line while the next bytes keep
//   flowing; only a second newline waiting behind an untaken line word stops
//   the byte channel, and it resumes the cycle the line word is taken
`include "nmea_line_checksum_checker_macros.svh"

module nmea_line_checksum_checker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [7:0]               data_byte,
	input  logic                     byte_valid,
	output logic                     byte_ready,
	output logic [1:0]               line_status,
	output logic [nlcc_pkg::LEN_W-1:0] line_length,
	output logic [7:0]               computed_checksum,
	output logic [7:0]               received_checksum,
	output logic                     line_valid,
	input  logic                     line_ready
);
	import nlcc_pkg::*;

	// input register
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         is_lf_s1;
	logic         adv_s1;

	// result register
	logic         out_valid_q;
	line_result_t out_q;
	line_result_t result;

	assign is_lf_s1 = (byte_s1 == CH_LF);

	// a held word moves on unless it is a newline and the result slot is full and not being taken
	assign adv_s1 = valid_s1 && (!is_lf_s1 || !out_valid_q || line_ready);
	assign byte_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			byte_s1 <= data_byte;
		end
	end

	// line state and the result of the line so far
	nlcc_line_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.data   (byte_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && is_lf_s1) begin
			out_valid_q <= 1'b1;
		end else if (line_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && is_lf_s1) begin
			out_q <= result;
		end
	end

	assign line_valid = out_valid_q;
	assign line_status = out_q.status;
	assign line_length = out_q.length;
	assign computed_checksum = out_q.comp;
	assign received_checksum = out_q.recv;

	// a newline that moves on always shows up as a line word next cycle
	`NLCC_ASSERT_NEXT(a_lf_gives_line, clk, arst_n, adv_s1 && is_lf_s1, line_valid)
	// the byte side only stops behind an untaken line word
	`NLCC_ASSERT_NOW(a_stall_cause, clk, arst_n, !byte_ready, line_valid && !line_ready)
	// an empty line carries no length and no checksums
	`NLCC_ASSERT_NOW(a_empty_zero, clk, arst_n, line_valid && line_status == ST_EMPTY,
		line_length == '0 && computed_checksum == 8'd0 && received_checksum == 8'd0)
	// a good line has matching checksums
	`NLCC_ASSERT_NOW(a_good_match, clk, arst_n, line_valid && line_status == ST_GOOD,
		computed_checksum == received_checksum)

endmodule

// File: hdl/nlcc_line_state.sv
module nlcc_line_state (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            data,
	output nlcc_pkg::line_result_t result
);
	import nlcc_pkg::*;

	logic [CNT_W-1:0] count_q, count_d;
	phase_t           phase_q, phase_d;
	logic [7:0]       xor_q, xor_d;
	logic [3:0]       hi_q, hi_d;
	logic [3:0]       lo_q, lo_d;
	logic [1:0]       digits_q, digits_d;
	logic             herr_q, herr_d;
	logic             ended_q, ended_d;
	hex_t             hx;
	logic [7:0]       recv;
	logic             nmea;

	assign hx = hex_decode(data);

	// result as the line stands now, taken when a newline steps in
	always_comb begin
		nmea = (phase_q == PH_BODY) || (phase_q == PH_DIGITS);
		recv = (digits_q == 2'd2 && !herr_q) ? {hi_q, lo_q} : 8'd0;
		result.length = LEN_W'(count_q);
		result.comp = 8'd0;
		result.recv = 8'd0;
		if (count_q == '0) begin
			result.status = ST_EMPTY;
		end else if (nmea) begin
			result.comp = xor_q;
			result.recv = recv;
			if (phase_q == PH_DIGITS && digits_q == 2'd2 && !herr_q && xor_q == recv) begin
				result.status = ST_GOOD;
			end else begin
				result.status = ST_BAD;
			end
		end else begin
			result.status = ST_PLAIN;
		end
	end

	always_comb begin
		count_d = count_q;
		phase_d = phase_q;
		xor_d = xor_q;
		hi_d = hi_q;
		lo_d = lo_q;
		digits_d = digits_q;
		herr_d = herr_q;
		ended_d = ended_q;
		if (data == CH_LF) begin
			count_d = '0;
			phase_d = PH_FIRST;
			xor_d = 8'd0;
			hi_d = 4'd0;
			lo_d = 4'd0;
			digits_d = 2'd0;
			herr_d = 1'b0;
			ended_d = 1'b0;
		end else if (data != CH_CR && count_q < CNT_W'(LINE_CAPACITY - 1)) begin
			count_d = count_q + 1'b1;
			if (!ended_q) begin
				if (data == CH_NUL) begin
					ended_d = 1'b1;
					if (phase_q == PH_FIRST) begin
						phase_d = PH_PLAIN;
					end
				end else begin
					case (phase_q)
						PH_FIRST: begin
							phase_d = (data == CH_DOLLAR) ? PH_BODY : PH_PLAIN;
						end
						PH_BODY: begin
							if (data == CH_STAR) begin
								phase_d = PH_DIGITS;
							end else begin
								xor_d = xor_q ^ data;
							end
						end
						PH_DIGITS: begin
							if (digits_q < 2'd2) begin
								if (!hx.ok) begin
									herr_d = 1'b1;
								end
								if (digits_q == 2'd0) begin
									hi_d = hx.nibble;
								end else begin
									lo_d = hx.nibble;
								end
								digits_d = digits_q + 2'd1;
							end
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			phase_q <= PH_FIRST;
			xor_q <= 8'd0;
			hi_q <= 4'd0;
			lo_q <= 4'd0;
			digits_q <= 2'd0;
			herr_q <= 1'b0;
			ended_q <= 1'b0;
		end else if (step) begin
			count_q <= count_d;
			phase_q <= phase_d;
			xor_q <= xor_d;
			hi_q <= hi_d;
			lo_q <= lo_d;
			digits_q <= digits_d;
			herr_q <= herr_d;
			ended_q <= ended_d;
		end
	end

endmodule

// File: tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nlcc_pkg::*;

	localparam int CYCLE_LIMIT  = 200_000;
	localparam int REPORT_LIMIT = 10;
	localparam int RANDOM_BYTES = 400;
	localparam int RANDOM_LINES = 16;
	localparam int TAIL_CYCLES  = 8;

	typedef enum int {RX_FREE, RX_CHOPPY, RX_LONG} rx_mode_t;

	// line checker predictor plus the store of expected line words
	class line_scoreboard;
		int         stored;
		phase_t     phase;
		logic [7:0] run_xor;
		logic [3:0] hi_nib;
		logic [3:0] lo_nib;
		int         digits;
		bit         hex_bad;
		bit         text_done;

		line_result_t expected_lines[$];
		int mismatches;
		int lines_checked;
		int dropped_bytes;
		int status_seen[4];

		function new();
			clear();
		endfunction

		function void clear();
			stored    = 0;
			phase     = PH_FIRST;
			run_xor   = 8'h00;
			hi_nib    = 4'h0;
			lo_nib    = 4'h0;
			digits    = 0;
			hex_bad   = 1'b0;
			text_done = 1'b0;
		endfunction

		// accepted byte word: update the line state, queue a line word on newline
		function void note_byte(logic [7:0] b);
			line_result_t r;
			logic [3:0]   nib;
			if (b == CH_CR)
				return;
			if (b != CH_LF) begin
				if (stored + 1 >= LINE_CAPACITY) begin
					dropped_bytes++;
					return;
				end
				stored++;
				if (text_done)
					return;
				if (b == CH_NUL) begin
					text_done = 1'b1;
					if (phase == PH_FIRST)
						phase = PH_PLAIN;
					return;
				end
				case (phase)
					PH_FIRST: phase = (b == CH_DOLLAR) ? PH_BODY : PH_PLAIN;
					PH_BODY: begin
						if (b == CH_STAR)
							phase = PH_DIGITS;
						else
							run_xor ^= b;
					end
					PH_DIGITS: begin
						if (digits < 2) begin
							nib = 4'h0;
							if (b >= 8'h30 && b <= 8'h39)
								nib = 4'(b - 8'h30);
							else if (b >= 8'h41 && b <= 8'h46)
								nib = 4'(b - 8'h37);
							else if (b >= 8'h61 && b <= 8'h66)
								nib = 4'(b - 8'h57);
							else
								hex_bad = 1'b1;
							if (digits == 0)
								hi_nib = nib;
							else
								lo_nib = nib;
							digits++;
						end
					end
					default: ;
				endcase
				return;
			end
			r.status = ST_EMPTY;
			r.length = LEN_W'(stored);
			r.comp   = 8'h00;
			r.recv   = 8'h00;
			if (stored == 0) begin
				r.status = ST_EMPTY;
			end else if (phase == PH_BODY || phase == PH_DIGITS) begin
				r.comp = run_xor;
				if (digits == 2 && !hex_bad)
					r.recv = {hi_nib, lo_nib};
				r.status = (phase == PH_DIGITS && digits == 2 && !hex_bad && r.comp == r.recv)
					? ST_GOOD : ST_BAD;
			end else begin
				r.status = ST_PLAIN;
			end
			expected_lines.push_back(r);
			clear();
		endfunction

		// accepted line word: compare with the oldest expectation
		function void check_line(logic [1:0] st, logic [LEN_W-1:0] len,
				logic [7:0] comp, logic [7:0] recv);
			line_result_t e;
			if (expected_lines.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected line word: status %0d length %0d comp %02h recv %02h",
						st, len, comp, recv);
				return;
			end
			e = expected_lines.pop_front();
			lines_checked++;
			status_seen[int'(e.status)]++;
			if (st !== e.status || len !== e.length || comp !== e.comp || recv !== e.recv) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("line %0d mismatch: status %0d/%0d length %0d/%0d (expected/actual)",
						lines_checked, e.status, st, e.length, len);
					$display("  comp %02h/%02h recv %02h/%02h (expected/actual)",
						e.comp, comp, e.recv, recv);
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n     = 1'b0;
	logic [7:0]           data_byte  = 8'h00;
	logic                 byte_valid = 1'b0;
	logic                 byte_ready;
	logic [1:0]           line_status;
	logic [LEN_W-1:0]     line_length;
	logic [7:0]           computed_checksum;
	logic [7:0]           received_checksum;
	logic                 line_valid;
	logic                 line_ready = 1'b0;

	line_scoreboard line_sb = new();

	logic [7:0] line_bytes[$];   // bytes of the line being sent
	int         burst_left = 0;  // byte words left in the current sender burst
	int         bytes_sent = 0;
	int         cycle_count = 0;
	rx_mode_t   rx_mode = RX_FREE;
	int         rx_hold = 0;     // cycles left in a long receiver stall

	nmea_line_checksum_checker u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.data_byte         (data_byte),
		.byte_valid        (byte_valid),
		.byte_ready        (byte_ready),
		.line_status       (line_status),
		.line_length       (line_length),
		.computed_checksum (computed_checksum),
		.received_checksum (received_checksum),
		.line_valid        (line_valid),
		.line_ready        (line_ready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog: a generous bound well above the slowest legal run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d line words outstanding",
				cycle_count, line_sb.expected_lines.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// both monitors sample the pre-edge values, so the order of processes does not matter
	always @(posedge clk) begin
		if (arst_n) begin
			if (line_valid && line_ready)
				line_sb.check_line(line_status, line_length, computed_checksum, received_checksum);
			if (byte_valid && byte_ready)
				line_sb.note_byte(data_byte);
		end
	end

	// receiver: switches between free flow, choppy ready and long stalls
	always @(posedge clk) begin
		if (cycle_count % 97 == 0)
			rx_mode = rx_mode_t'($urandom_range(0, 2));
		if (rx_hold > 0) begin
			rx_hold--;
			line_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_FREE:   line_ready <= 1'b1;
				RX_CHOPPY: line_ready <= 1'($urandom_range(0, 1));
				default: begin
					if ($urandom_range(0, 7) == 0)
						rx_hold = $urandom_range(1, 30);
					line_ready <= (rx_hold == 0);
				end
			endcase
		end
	end

	// one byte word; the sender idles between bursts of random length
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			// a third of the bursts follow on with no gap at all
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		data_byte  <= b;
		byte_valid <= 1'b1;
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	// stray carriage returns are sprinkled in, they must never disturb the line
	task automatic send_line();
		foreach (line_bytes[i]) begin
			if ($urandom_range(0, 24) == 0)
				send_byte(CH_CR);
			send_byte(line_bytes[i]);
		end
		line_bytes.delete();
	endtask

	// sender holds off until every line word has come back
	task automatic drain();
		byte_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (line_sb.expected_lines.size() != 0) @(posedge clk);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_bytes.push_back(8'(s[i]));
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return 8'h30 + 8'(n);
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
	endfunction

	// body byte: never a star, newline or carriage return, never zero
	function automatic logic [7:0] body_char(input bit wide);
		logic [7:0] c;
		c = wide ? 8'($urandom_range(1, 255)) : 8'($urandom_range(8'h20, 8'h7e));
		if (c == CH_STAR || c == CH_LF || c == CH_CR)
			c ^= 8'h40;
		return c;
	endfunction

	// one random line into line_bytes, mostly well-formed sentences
	task automatic build_line();
		int         pick;
		int         n;
		int         flaw;
		bit         wide;
		logic [7:0] sum;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 70 || (pick >= 92 && pick < 97)) begin
			if (pick >= 92)
				n = $urandom_range(90, 120);   // can run past the line buffer
			else if ($urandom_range(0, 9) == 0)
				n = $urandom_range(13, 60);
			else
				n = $urandom_range(0, 12);
			wide = ($urandom_range(0, 3) == 0);
			sum = 8'h00;
			line_bytes.push_back(CH_DOLLAR);
			repeat (n) begin
				c = body_char(wide);
				sum ^= c;
				line_bytes.push_back(c);
			end
			flaw = (pick >= 55 && pick < 70) ? $urandom_range(1, 5) : 0;
			case (flaw)
				0, 5: begin
					// for flaw 5, a zero byte hidden somewhere in an otherwise good sentence
					if (flaw == 5)
						line_bytes.insert($urandom_range(1, line_bytes.size()), CH_NUL);
					line_bytes.push_back(CH_STAR);
					line_bytes.push_back(hex_char(sum[7:4]));
					line_bytes.push_back(hex_char(sum[3:0]));
					if ($urandom_range(0, 4) == 0)
						repeat ($urandom_range(1, 4)) line_bytes.push_back(body_char(1'b1));
				end
				1: ;   // star missing
				2: begin
					line_bytes.push_back(CH_STAR);
					line_bytes.push_back(hex_char(sum[7:4]));
				end
				3: begin
					// flipping bit 6 of a hex digit never gives a hex digit
					line_bytes.push_back(CH_STAR);
					if ($urandom_range(0, 1)) begin
						line_bytes.push_back(hex_char(sum[7:4]) ^ 8'h40);
						line_bytes.push_back(hex_char(sum[3:0]));
					end else begin
						line_bytes.push_back(hex_char(sum[7:4]));
						line_bytes.push_back(hex_char(sum[3:0]) ^ 8'h40);
					end
				end
				default: begin
					sum ^= 8'($urandom_range(1, 255));
					line_bytes.push_back(CH_STAR);
					line_bytes.push_back(hex_char(sum[7:4]));
					line_bytes.push_back(hex_char(sum[3:0]));
				end
			endcase
		end else if (pick < 85) begin
			// plain text line, anything but a leading dollar
			c = 8'($urandom_range(0, 255));
			if (c == CH_DOLLAR || c == CH_LF || c == CH_CR)
				c = CH_NUL;
			line_bytes.push_back(c);
			repeat ($urandom_range(0, 15)) begin
				c = 8'($urandom_range(0, 255));
				line_bytes.push_back((c == CH_LF) ? CH_STAR : c);
			end
		end else if (pick < 92) begin
			if ($urandom_range(0, 1))
				line_bytes.push_back(CH_CR);
		end else begin
			// raw noise, may hold newlines of its own
			repeat ($urandom_range(1, 20)) line_bytes.push_back(8'($urandom_range(0, 255)));
		end
		line_bytes.push_back(CH_LF);
	endtask

	initial begin
		int lines_sent;
		lines_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty line
		line_bytes.push_back(CH_LF);
		// good sentence, lower-case digits, carriage return inside, byte after the digits
		put_text("$az");
		line_bytes.push_back(CH_CR);
		put_text("*1bQ");
		line_bytes.push_back(CH_LF);
		// zero byte first: not a sentence
		line_bytes.push_back(CH_NUL);
		put_text("x");
		line_bytes.push_back(CH_LF);
		// top byte value in the body, bad second digit
		line_bytes.push_back(CH_DOLLAR);
		line_bytes.push_back(8'hFF);
		put_text("*Fg");
		line_bytes.push_back(CH_LF);
		// zero byte ends the text before the star, so no star is seen
		put_text("$A");
		line_bytes.push_back(CH_NUL);
		put_text("*41");
		line_bytes.push_back(CH_LF);
		send_line();
		drain();

		// random lines, with an occasional full drain
		while (bytes_sent < RANDOM_BYTES || lines_sent < RANDOM_LINES) begin
			build_line();
			send_line();
			lines_sent++;
			if ($urandom_range(0, 29) == 0)
				drain();
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d byte words; checked %0d lines: %0d empty, %0d plain, %0d good, %0d bad",
			bytes_sent, line_sb.lines_checked, line_sb.status_seen[0], line_sb.status_seen[1],
			line_sb.status_seen[2], line_sb.status_seen[3]);
		$display("%0d bytes dropped past the line buffer, %0d mismatches",
			line_sb.dropped_bytes, line_sb.mismatches);
		if (line_sb.mismatches == 0 && line_sb.expected_lines.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: nmea_line_checksum_checker.f
+incdir+hdl
hdl/nlcc_pkg.sv
hdl/nlcc_line_state.sv
hdl/nmea_line_checksum_checker.sv
tb/sv/tb.sv
